>>> rtl/bgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

    // Default sizing of the grid store and coordinate fraction.
    localparam int DEF_MAX_SIDE  = 64;
    localparam int DEF_FRAC_BITS = 8;

    // Fixed field widths.
    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 16;
    localparam int LOAD_IDX_W = 12;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    // Input item kinds (also the kind bit of a queued item).
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_AXIS = 2'd2;

    // Axis codes of zero_axis.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Result of an out-of-box query.
    localparam logic [VALUE_W-1:0] ERR_VALUE = 32'hFFFF_FFFF;

    // Queued item layout: kind, error, four zero flags, four addresses,
    // four weights, load value (lowest bits first).
    function automatic int entry_width(input int max_side, input int frac_bits);
        return 6 + 4 * $clog2(max_side * max_side) + 4 * (2 * frac_bits + 2) + VALUE_W;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: load_index, load_value, coord_x, coord_y
//                                           tuser: op
// m_*       out        m_tvalid / m_tready  tdata: value; tuser: error
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a query result passes the
// queue, store read, multiply, pair add and round/saturate registers in order.
// Loads write all four store copies and give no result.
// Reset clears control and the config registers; the store is not cleared.
// A stalled output holds the whole back pipeline; a two-entry queue lets the
// front keep accepting until it fills.

module bilinear_grid_interpolator #(
    parameter int MAX_SIDE  = bgi_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = bgi_pkg::DEF_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bgi_pkg::SIZE_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] load_index, [43:12] load_value, [59:44] coord_x, [75:60] coord_y
    input  wire logic [bgi_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] op
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] value
    output logic      [bgi_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] error
    output logic                                 m_tuser
);

    localparam int ENTRY_W = bgi_pkg::entry_width(MAX_SIDE, FRAC_BITS);

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    // Front: hold config, classify items, decode coordinates to corners.
    bgi_front #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the front from back-end stalls.
    bgi_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: store writes, corner reads, weighted sum, round and saturate.
    bgi_back #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/bgi_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bgi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_front #(
    parameter int MAX_SIDE  = bgi_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = bgi_pkg::DEF_FRAC_BITS,
    parameter int ENTRY_W   = bgi_pkg::entry_width(MAX_SIDE, FRAC_BITS)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bgi_pkg::SIZE_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bgi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output logic      [ENTRY_W-1:0]              push_data
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int WX_W   = FRAC_BITS + 1;
    localparam int WW     = 2 * FRAC_BITS + 2;
    localparam int MW     = 2 * SIDE_W;
    localparam logic [15:0]     HALF = 16'(1 << (FRAC_BITS - 1));
    localparam logic [WX_W-1:0] ONE  = WX_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic              err;
        logic              lo;
        logic              hi;
        logic [SIDE_W-1:0] i0;
        logic [SIDE_W-1:0] i1;
        logic [WX_W-1:0]   w;
    } axis_t;

    logic [bgi_pkg::SIZE_W-1:0] size_x_reg;
    logic [bgi_pkg::SIZE_W-1:0] size_y_reg;
    logic                       zero_axis_reg;

    logic [bgi_pkg::LOAD_IDX_W-1:0] load_index;
    logic [bgi_pkg::VALUE_W-1:0]    load_value;
    logic [bgi_pkg::COORD_W-1:0]    coord_x;
    logic [bgi_pkg::COORD_W-1:0]    coord_y;

    logic [SIDE_W-1:0] sx;
    logic [SIDE_W-1:0] sy;
    axis_t             ax;
    axis_t             ay;
    logic              zx;
    logic              zy;
    logic [3:0]        zero;
    logic [AW-1:0]     addr [4];
    logic [WW-1:0]     wgt [4];
    logic [WX_W-1:0]   omx;
    logic [WX_W-1:0]   omy;
    logic              load_ok;

    function automatic logic [SIDE_W-1:0] eff_size(input logic [bgi_pkg::SIZE_W-1:0] s);
        if (s == '0)
        begin
            return SIDE_W'(1);
        end
        if (int'(s) > MAX_SIDE)
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(s);
    endfunction

    // Split one coordinate into cell indexes, edge flags, error flag and weight.
    function automatic axis_t decode_axis(input logic [15:0] c, input logic [SIDE_W-1:0] s);
        logic [15:0]          ch;
        logic [SIDE_W-1:0]    k;
        logic [FRAC_BITS-1:0] fr;
        axis_t                r;
        ch    = {1'b0, c[14:0]} + HALF;
        k     = SIDE_W'(ch >> FRAC_BITS);
        fr    = ch[FRAC_BITS-1:0];
        r.err = c[15] || (32'(c[14:0]) > (32'(s) << FRAC_BITS));
        r.lo  = (k == '0);
        r.hi  = (k >= s);
        r.i0  = r.lo ? '0 : k - SIDE_W'(1);
        r.i1  = r.hi ? s - SIDE_W'(1) : k;
        if (r.lo)
        begin
            r.w = WX_W'(c[14:0]) << 1;
        end
        else if (r.hi)
        begin
            r.w = WX_W'(fr) << 1;
        end
        else
        begin
            r.w = WX_W'(fr);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [SIDE_W-1:0] ix,
                                              input logic [SIDE_W-1:0] iy,
                                              input logic [SIDE_W-1:0] s);
        return AW'(MW'(ix) * MW'(s) + MW'(iy));
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= bgi_pkg::SIZE_RESET;
            size_y_reg    <= bgi_pkg::SIZE_RESET;
            zero_axis_reg <= bgi_pkg::AXIS_X;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bgi_pkg::REG_SIZE_X:    size_x_reg    <= cfg_data;
                bgi_pkg::REG_SIZE_Y:    size_y_reg    <= cfg_data;
                bgi_pkg::REG_ZERO_AXIS: zero_axis_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign load_index = s_tdata[11:0];
    assign load_value = s_tdata[43:12];
    assign coord_x    = s_tdata[59:44];
    assign coord_y    = s_tdata[75:60];

    always_comb
    begin
        sx  = eff_size(size_x_reg);
        sy  = eff_size(size_y_reg);
        ax  = decode_axis(coord_x, sx);
        ay  = decode_axis(coord_y, sy);
        zx  = (zero_axis_reg == bgi_pkg::AXIS_X);
        zy  = !zx;
        omx = ONE - ax.w;
        omy = ONE - ay.w;

        // Neighbors beyond an edge: zero on the forced axis, and where beyond both edges.
        zero[0] = (ax.lo && ay.lo) || (ax.lo && zx) || (ay.lo && zy);
        zero[1] = (ax.lo && ay.hi) || (ax.lo && zx) || (ay.hi && zy);
        zero[2] = (ax.hi && ay.lo) || (ax.hi && zx) || (ay.lo && zy);
        zero[3] = (ax.hi && ay.hi) || (ax.hi && zx) || (ay.hi && zy);

        addr[0] = addr_of(ax.i0, ay.i0, sy);
        addr[1] = addr_of(ax.i0, ay.i1, sy);
        addr[2] = addr_of(ax.i1, ay.i0, sy);
        addr[3] = addr_of(ax.i1, ay.i1, sy);

        wgt[0] = WW'(omx) * WW'(omy);
        wgt[1] = WW'(omx) * WW'(ay.w);
        wgt[2] = WW'(ax.w) * WW'(omy);
        wgt[3] = WW'(ax.w) * WW'(ay.w);

        // A load takes its store index in the first address slot.
        load_ok = (32'(load_index) < DEPTH);
        if (s_tuser == bgi_pkg::OP_LOAD)
        begin
            addr[0] = AW'(load_index);
        end

        push_data = {load_value,
                     wgt[3], wgt[2], wgt[1], wgt[0],
                     addr[3], addr[2], addr[1], addr[0],
                     zero, (ax.err || ay.err), s_tuser};
    end

    // Drop out-of-range loads here; they never reach the store.
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && ((s_tuser == bgi_pkg::OP_QUERY) || load_ok);

endmodule

`default_nettype wire

>>> rtl/bgi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_back #(
    parameter int MAX_SIDE  = bgi_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = bgi_pkg::DEF_FRAC_BITS,
    parameter int ENTRY_W   = bgi_pkg::entry_width(MAX_SIDE, FRAC_BITS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire logic [ENTRY_W-1:0]            pop_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [bgi_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                               m_tuser
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = 2 * FRAC_BITS + 2;
    localparam int PW    = bgi_pkg::VALUE_W + WW + 1;
    localparam int SW    = PW + 2;
    localparam int A_LO  = 6;
    localparam int W_LO  = A_LO + 4 * AW;
    localparam int V_LO  = W_LO + 4 * WW;
    localparam logic signed [SW-1:0] RND    = SW'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32'h7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic                        adv;
    logic                        in_kind;
    logic                        in_err;
    logic [3:0]                  in_zero;
    logic [AW-1:0]               in_addr [4];
    logic [WW-1:0]               in_wgt [4];
    logic [bgi_pkg::VALUE_W-1:0] in_value;
    logic                        do_write;

    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic                        out_valid_reg;
    logic                        err1_reg;
    logic                        err2_reg;
    logic                        err3_reg;
    logic [3:0]                  zero1_reg;
    logic [WW-1:0]               wgt1_reg [4];
    logic signed [31:0]          rd_reg [4];
    logic signed [PW-1:0]        prod_reg [4];
    logic signed [SW-1:0]        s01_reg;
    logic signed [SW-1:0]        s23_reg;
    logic [31:0]                 value_reg;
    logic                        error_reg;

    logic signed [SW-1:0]        total;
    logic signed [SW-1:0]        shifted;
    logic [31:0]                 value_next;

    // Whole pipeline advances unless the output item is stalled.
    assign adv       = !out_valid_reg || m_tready;
    assign pop_ready = adv;

    always_comb
    begin
        in_kind  = pop_data[0];
        in_err   = pop_data[1];
        in_zero  = pop_data[5:2];
        in_value = pop_data[V_LO +: bgi_pkg::VALUE_W];
        for (int k = 0; k < 4; k++)
        begin
            in_addr[k] = pop_data[A_LO + k * AW +: AW];
            in_wgt[k]  = pop_data[W_LO + k * WW +: WW];
        end
    end

    assign do_write = adv && pop_valid && (in_kind == bgi_pkg::OP_LOAD);

    // Four copies of the store, one per corner read; every load writes all.
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [31:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (do_write)
            begin
                mem[in_addr[0]] <= in_value;
            end
            if (adv)
            begin
                rd_reg[g] <= mem[in_addr[g]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pop_valid && (in_kind == bgi_pkg::OP_QUERY);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_comb
    begin
        total   = s01_reg + s23_reg + RND;
        shifted = total >>> (2 * FRAC_BITS);
        if (err3_reg)
        begin
            value_next = bgi_pkg::ERR_VALUE;
        end
        else if (shifted > SAT_HI)
        begin
            value_next = SAT_HI[31:0];
        end
        else if (shifted < SAT_LO)
        begin
            value_next = SAT_LO[31:0];
        end
        else
        begin
            value_next = shifted[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err1_reg  <= in_err;
            zero1_reg <= in_zero;
            for (int k = 0; k < 4; k++)
            begin
                wgt1_reg[k] <= in_wgt[k];
                prod_reg[k] <= zero1_reg[k] ? $signed(PW'(0))
                             : rd_reg[k] * $signed({1'b0, wgt1_reg[k]});
            end
            err2_reg  <= err1_reg;
            s01_reg   <= SW'(prod_reg[0]) + SW'(prod_reg[1]);
            s23_reg   <= SW'(prod_reg[2]) + SW'(prod_reg[3]);
            err3_reg  <= err2_reg;
            value_reg <= value_next;
            error_reg <= err3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = error_reg;

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

// Tracks the grid store and the register settings, predicts the result of each
// query and compares the results against it in order.
class interp_scoreboard;
    logic [31:0] grid [4096];
    logic [6:0]  size_x;
    logic [6:0]  size_y;
    logic        zero_axis;
    logic [31:0] exp_value [$];
    logic        exp_error [$];
    int          fail_count;

    function new();
        size_x     = bgi_pkg::SIZE_RESET;
        size_y     = bgi_pkg::SIZE_RESET;
        zero_axis  = bgi_pkg::AXIS_X;
        fail_count = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [6:0] data);
        if (index == bgi_pkg::REG_SIZE_X) size_x = data;
        else if (index == bgi_pkg::REG_SIZE_Y) size_y = data;
        else if (index == bgi_pkg::REG_ZERO_AXIS) zero_axis = data[0];
    endfunction

    function int pending();
        return exp_value.size();
    endfunction

    function longint sample_at(longint ix, longint iy, longint sx, longint sy);
        if (ix > sx - 1) ix = sx - 1;
        if (iy > sy - 1) iy = sy - 1;
        if (ix < 0) ix = 0;
        if (iy < 0) iy = 0;
        return longint'($signed(grid[ix * sy + iy]));
    endfunction

    // Bilinear blend of the four samples around (xr, yr), with the edge rules.
    function void predict_query(logic [15:0] cx, logic [15:0] cy);
        longint one, half, sx, sy, lx, ly, xr, yr, kx, ky;
        longint x0, x1, y0, y1, wx, wy, ix0, ix1, iy0, iy1;
        longint f00, f01, f10, f11, acc, res;
        bit xlo, xhi, ylo, yhi, zx, zy;
        one  = 256;
        half = 128;
        sx = (size_x < 1) ? 1 : (size_x > 64) ? 64 : size_x;
        sy = (size_y < 1) ? 1 : (size_y > 64) ? 64 : size_y;
        lx = sx * one;
        ly = sy * one;
        xr = longint'($signed(cx));
        yr = longint'($signed(cy));
        if (xr < 0 || xr > lx || yr < 0 || yr > ly) begin
            exp_value.push_back(bgi_pkg::ERR_VALUE);
            exp_error.push_back(1'b1);
            return;
        end
        kx = (xr + half) / one;
        ky = (yr + half) / one;
        x0 = kx > 0 ? kx * one - half : 0;
        y0 = ky > 0 ? ky * one - half : 0;
        x1 = kx * one + half;
        if (x1 > lx) x1 = lx;
        y1 = ky * one + half;
        if (y1 > ly) y1 = ly;
        wx = xr - x0;
        if (x1 - x0 == half) wx = wx * 2;
        wy = yr - y0;
        if (y1 - y0 == half) wy = wy * 2;
        ix0 = kx > 0 ? kx - 1 : 0;
        ix1 = kx;
        iy0 = ky > 0 ? ky - 1 : 0;
        iy1 = ky;
        xlo = xr < half;
        xhi = xr >= lx - half;
        ylo = yr < half;
        yhi = yr >= ly - half;
        zx  = (zero_axis == bgi_pkg::AXIS_X);
        zy  = !zx;

        if ((xlo && ylo) || (xlo && zx) || (ylo && zy)) f00 = 0;
        else f00 = sample_at(ix0, iy0, sx, sy);

        if ((xlo && yhi) || (xlo && zx) || (yhi && zy)) f01 = 0;
        else if (!xlo && yhi && zx) f01 = sample_at(ix0, sy - 1, sx, sy);
        else f01 = sample_at(ix0, iy1, sx, sy);

        if ((xhi && ylo) || (xhi && zx) || (ylo && zy)) f10 = 0;
        else if (xhi && !ylo && zy) f10 = sample_at(sx - 1, iy0, sx, sy);
        else f10 = sample_at(ix1, iy0, sx, sy);

        if ((xhi && yhi) || (xhi && zx) || (yhi && zy)) f11 = 0;
        else if (xhi && !yhi && zy) f11 = sample_at(sx - 1, iy1, sx, sy);
        else if (!xhi && yhi && zx) f11 = sample_at(ix1, sy - 1, sx, sy);
        else f11 = sample_at(ix1, iy1, sx, sy);

        acc = f00 * ((one - wx) * (one - wy)) + f01 * ((one - wx) * wy)
            + f10 * (wx * (one - wy)) + f11 * (wx * wy);
        // Round to nearest, ties up: add half an LSB, then floor.
        res = (acc + 64'sd32768) >>> 16;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        exp_value.push_back(res[31:0]);
        exp_error.push_back(1'b0);
    endfunction

    function void note_item(logic op, logic [11:0] idx, logic [31:0] val,
                            logic [15:0] cx, logic [15:0] cy);
        if (op == bgi_pkg::OP_LOAD) grid[idx] = val;
        else predict_query(cx, cy);
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task check_result(logic [31:0] value, logic err);
        logic [31:0] want_value;
        logic        want_error;
        if (exp_value.size() == 0) begin
            report($sformatf("unexpected result value=%h error=%b", value, err));
            return;
        end
        want_value = exp_value.pop_front();
        want_error = exp_error.pop_front();
        if (value !== want_value)
            report($sformatf("value %h, expected %h", value, want_value));
        if (err !== want_error)
            report($sformatf("error %b, expected %b", err, want_error));
    endtask
endclass

module tb;
    // Index 3 is not a register; writes to it must be ignored.
    localparam logic [bgi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bgi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bgi_pkg::SIZE_W-1:0]    cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bgi_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bgi_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    interp_scoreboard sb = new();
    bit  written [4096];
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    int  recv_hold = 0;

    always #2 clk = ~clk;

    bilinear_grid_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Idle a random wait before each item; now and then switch into a gap-free stretch.
    function automatic int draw_wait(ref bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Result side: take an item, then drop tready for a random hold.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
                recv_hold = draw_wait(recv_calm);
            end else if (recv_hold > 0) begin
                recv_hold--;
            end
            m_tready <= (recv_hold == 0);
        end
    end

    // Present one item after a random gap; hold valid high across
    // back-to-back items so it never toggles within one step.
    task automatic send_item(logic op, logic [11:0] idx, logic [31:0] val,
                             logic [15:0] cx, logic [15:0] cy);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, cy, cx, val, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, idx, val, cx, cy);
        if (op == bgi_pkg::OP_LOAD) written[idx] = 1'b1;
    endtask

    task automatic send_load(logic [11:0] idx, logic [31:0] val);
        send_item(bgi_pkg::OP_LOAD, idx, val, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(logic [15:0] cx, logic [15:0] cy);
        send_item(bgi_pkg::OP_QUERY, 12'($urandom), $urandom, cx, cy);
    endtask

    // Drain all outstanding results, then let the pipeline settle before a write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Drop valid for one cycle after the write so back-to-back writes never
    // assign it twice in one step.
    task automatic write_reg(logic [bgi_pkg::CFG_IDX_W-1:0] index,
                             logic [bgi_pkg::SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int eff_side(logic [6:0] s);
        return (s < 1) ? 1 : (s > 64) ? 64 : int'(s);
    endfunction

    // Set the grid shape and load every entry it can read that is still empty.
    task automatic set_grid(logic [6:0] sx, logic [6:0] sy, logic axis);
        int ex, ey;
        drain();
        write_reg(bgi_pkg::REG_SIZE_X, sx);
        write_reg(bgi_pkg::REG_SIZE_Y, sy);
        write_reg(bgi_pkg::REG_ZERO_AXIS, {6'b0, axis});
        ex = eff_side(sx);
        ey = eff_side(sy);
        for (int ix = 0; ix < ex; ix++)
            for (int iy = 0; iy < ey; iy++)
                if (!written[ix * ey + iy]) send_load(12'(ix * ey + iy), $urandom);
    endtask

    // Some random loads; among queries mostly in-box points, some hugging the edges, the rest anywhere.
    task automatic random_phase(int count);
        int lx, ly, pick;
        lx = eff_side(sb.size_x) * 256;
        ly = eff_side(sb.size_y) * 256;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                send_load(12'($urandom), $urandom);
            end else if (pick < 7) begin
                send_query(16'($urandom_range(0, lx)), 16'($urandom_range(0, ly)));
            end else if (pick < 9) begin
                send_query(16'($urandom_range(0, 1) ? $urandom_range(0, 140)
                                                    : lx - $urandom_range(0, 140)),
                           16'($urandom_range(0, 1) ? $urandom_range(0, 140)
                                                    : ly - $urandom_range(0, 140)));
            end else begin
                send_query(16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 4 x 3 grid, extreme samples, corners, edges, outside points.
        set_grid(7'd4, 7'd3, bgi_pkg::AXIS_X);
        send_load(12'd0, 32'h7FFF_FFFF);
        send_load(12'd11, 32'h8000_0000);
        send_load(12'd4095, 32'h1234_5678);
        send_query(16'd0, 16'd0);
        send_query(16'd1024, 16'd768);
        send_query(16'd0, 16'd768);
        send_query(16'd1024, 16'd0);
        send_query(16'd128, 16'd128);
        send_query(16'd60, 16'd400);
        send_query(16'd1000, 16'd700);
        send_query(16'd512, 16'd384);
        send_query(16'hFFFF, 16'd10);
        send_query(16'd1025, 16'd10);
        send_query(16'd10, 16'd769);
        send_query(16'h8000, 16'h7FFF);
        set_grid(7'd4, 7'd3, bgi_pkg::AXIS_Y);
        write_reg(REG_UNUSED, 7'h7F);
        send_query(16'd0, 16'd0);
        send_query(16'd60, 16'd400);
        send_query(16'd1000, 16'd700);
        send_query(16'd300, 16'd20);
        send_query(16'd1024, 16'd768);

        // Random phases over several shapes, the extremes among them.
        set_grid(7'd64, 7'd1, bgi_pkg::AXIS_X);
        random_phase(70);
        set_grid(7'd1, 7'd1, bgi_pkg::AXIS_Y);
        random_phase(50);
        set_grid(7'd0, 7'd100, bgi_pkg::AXIS_X);
        random_phase(60);
        set_grid(7'd2, 7'd7, bgi_pkg::AXIS_Y);
        random_phase(60);
        set_grid(7'd5, 7'd5, bgi_pkg::AXIS_X);
        random_phase(70);
        set_grid(7'(1 + $urandom_range(0, 7)), 7'(1 + $urandom_range(0, 7)),
                 1'($urandom));
        random_phase(90);
        set_grid(7'd127, 7'd2, bgi_pkg::AXIS_Y);
        random_phase(70);

        drain();
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
